/* rtl/core/ljpf_pkg.sv */
// ----------------------------------------------------------------------------
// ljpf_pkg
// Request and response types, status codes and constants of the pair force
// pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  localparam logic [31:0] CUTOFF_RESET = 32'd196608;
  localparam logic [31:0] FORCE_LIMIT  = 32'd1310720000;

  typedef enum logic [1:0] {
    PS_OK         = 2'd0,
    PS_BEYOND     = 2'd1,
    PS_COINCIDENT = 2'd2
  } pair_status_t;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_pos_z;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_pos_z;
    logic        [31:0] first_epsilon;
    logic        [31:0] second_epsilon;
    logic        [31:0] first_sigma;
    logic        [31:0] second_sigma;
  } ljpf_req_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic        [1:0]  pair_status;
  } ljpf_resp_t;

endpackage

/* rtl/core/lennard_jones_pair_force.sv */
// ----------------------------------------------------------------------------
// lennard_jones_pair_force
// Lennard-Jones pair force with Lorentz-Berthelot mixing, Q16.16, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one pair request (two positions, two
//   epsilon/sigma sets). out_valid/out_ready/out_data return the clamped
//   force on the first particle and the pair status.
//   cfg_valid/cfg_ready/cfg_data write the cutoff radius; write it only
//   while no request is in flight.
//   Throughput: one request per cycle unless out_ready stalls the pipeline.
//   The depth is set by the 64-step quotient divider for (sigma^2 / r^2)
//   and the 31-step force divider, one bit per stage.
//   The epsilon square root runs alongside the first 32 divider stages.
//   Reset clears all valid bits and loads the cutoff with 3.0; no request is
//   in flight afterwards.
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force
  import ljpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ljpf_req_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ljpf_resp_t  out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int STG_SQ    = 1;
  localparam int STG_SUM   = 2;
  localparam int STG_CHK   = 3;
  localparam int STG_DIV0  = 4;
  localparam int NDIV      = 64;
  localparam int NSQRT     = 32;
  localparam int STG_P1    = STG_DIV0 + NDIV;
  localparam int STG_M1    = STG_P1 + 1;
  localparam int STG_P2    = STG_P1 + 2;
  localparam int STG_M2    = STG_P1 + 3;
  localparam int STG_P3    = STG_P1 + 4;
  localparam int STG_M3    = STG_P1 + 5;
  localparam int STG_G     = STG_P1 + 6;
  localparam int STG_P4    = STG_P1 + 7;
  localparam int STG_T     = STG_P1 + 8;
  localparam int STG_FP    = STG_P1 + 9;
  localparam int STG_FN    = STG_P1 + 10;
  localparam int STG_FDIV0 = STG_P1 + 11;
  localparam int NFDIV     = 31;
  localparam int STG_OUT   = STG_FDIV0 + NFDIV;
  localparam int NSTAGE    = STG_OUT + 1;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic [31:0]       sig;
    logic [63:0]       eprod;
    logic [2:0][63:0]  sq;
    logic [63:0]       s2;
    logic [65:0]       d2w;
    logic [63:0]       d2;
    logic [31:0]       s2lo;
    logic [63:0]       qrem;
    logic              qsat;
    logic [63:0]       q;
    logic [32:0]       srem;
    logic [31:0]       root;
    logic [3:0][63:0]  pp;
    logic [63:0]       q2;
    logic [63:0]       q3;
    logic [63:0]       q6;
    logic              gneg;
    logic [63:0]       gmag;
    logic [63:0]       e24;
    logic [63:0]       t;
    logic [2:0][63:0]  fl;
    logic [2:0][63:0]  fh;
    logic [2:0]        fsat;
    logic [2:0][63:0]  frem;
    logic [2:0][30:0]  flo;
    logic [2:0][30:0]  f;
    logic [2:0][31:0]  fo;
  } work_t;

  function automatic logic [3:0][63:0] partials(input logic [63:0] a, input logic [63:0] b);
    logic [3:0][63:0] r;
    r[0] = 64'(a[31:0]) * 64'(b[31:0]);
    r[1] = 64'(a[31:0]) * 64'(b[63:32]);
    r[2] = 64'(a[63:32]) * 64'(b[31:0]);
    r[3] = 64'(a[63:32]) * 64'(b[63:32]);
    return r;
  endfunction

  function automatic logic [63:0] combine(input logic [3:0][63:0] p);
    logic [127:0] full;
    full = 128'(p[0]) + (128'(p[1]) << 32) + (128'(p[2]) << 32) + (128'(p[3]) << 64);
    if (full[127:96] != 32'd0) begin
      return '1;
    end
    return full[95:32];
  endfunction

  function automatic work_t capture(input ljpf_req_t r);
    work_t w;
    logic signed [2:0][32:0] dxs;
    w = '0;
    dxs[0] = 33'(r.first_pos_x) - 33'(r.second_pos_x);
    dxs[1] = 33'(r.first_pos_y) - 33'(r.second_pos_y);
    dxs[2] = 33'(r.first_pos_z) - 33'(r.second_pos_z);
    for (int k = 0; k < 3; k++) begin
      w.neg[k] = dxs[k][32];
      w.mag[k] = dxs[k][32] ? 32'(-dxs[k]) : dxs[k][31:0];
    end
    w.eprod = 64'(r.first_epsilon) * 64'(r.second_epsilon);
    w.sig   = 32'((33'(r.first_sigma) + 33'(r.second_sigma)) >> 1);
    return w;
  endfunction

  function automatic work_t step(input int s, input work_t p, input logic [63:0] r2);
    work_t        n;
    logic [64:0]  r65;
    logic [34:0]  st;
    logic [33:0]  trial;
    logic [95:0]  nn;
    logic [63:0]  q6d;
    logic [31:0]  fm;
    n = p;
    if (s == STG_SQ) begin
      for (int k = 0; k < 3; k++) begin
        n.sq[k] = 64'(p.mag[k]) * 64'(p.mag[k]);
      end
      n.s2 = 64'(p.sig) * 64'(p.sig);
    end else if (s == STG_SUM) begin
      n.d2w = 66'(p.sq[0]) + 66'(p.sq[1]) + 66'(p.sq[2]);
    end else if (s == STG_CHK) begin
      if (p.d2w[65:64] != 2'd0 || p.d2w[63:0] > r2) begin
        n.status = PS_BEYOND;
      end else if (p.d2w == 66'd0) begin
        n.status = PS_COINCIDENT;
      end else begin
        n.status = PS_OK;
      end
      n.d2   = p.d2w[63:0];
      n.qrem = 64'(p.s2[63:32]);
      n.qsat = (64'(p.s2[63:32]) >= p.d2w[63:0]);
      n.s2lo = p.s2[31:0];
      n.q    = '0;
      n.srem = '0;
      n.root = '0;
    end else if (s >= STG_DIV0 && s < STG_P1) begin
      r65    = {p.qrem, p.s2lo[31]};
      n.s2lo = {p.s2lo[30:0], 1'b0};
      if (r65 >= {1'b0, p.d2}) begin
        n.qrem = 64'(r65 - {1'b0, p.d2});
        n.q    = {p.q[62:0], 1'b1};
      end else begin
        n.qrem = r65[63:0];
        n.q    = {p.q[62:0], 1'b0};
      end
      if (s == STG_P1 - 1 && p.qsat) begin
        n.q = '1;
      end
      if (s < STG_DIV0 + NSQRT) begin
        st      = {p.srem, p.eprod[63:62]};
        trial   = {p.root, 2'b01};
        n.eprod = {p.eprod[61:0], 2'b00};
        if (st >= {1'b0, trial}) begin
          n.srem = 33'(st - {1'b0, trial});
          n.root = {p.root[30:0], 1'b1};
        end else begin
          n.srem = st[32:0];
          n.root = {p.root[30:0], 1'b0};
        end
      end
    end else if (s == STG_P1) begin
      n.pp = partials(p.q, p.q);
    end else if (s == STG_M1) begin
      n.q2 = combine(p.pp);
    end else if (s == STG_P2) begin
      n.pp = partials(p.q2, p.q);
    end else if (s == STG_M2) begin
      n.q3 = combine(p.pp);
    end else if (s == STG_P3) begin
      n.pp = partials(p.q3, p.q3);
    end else if (s == STG_M3) begin
      n.q6 = combine(p.pp);
    end else if (s == STG_G) begin
      q6d = p.q6[63] ? '1 : {p.q6[62:0], 1'b0};
      if (q6d >= p.q3) begin
        n.gneg = 1'b0;
        n.gmag = q6d - p.q3;
      end else begin
        n.gneg = 1'b1;
        n.gmag = p.q3 - q6d;
      end
      n.e24 = ((64'(p.root) << 4) + (64'(p.root) << 3)) << 16;
    end else if (s == STG_P4) begin
      n.pp = partials(p.gmag, p.e24);
    end else if (s == STG_T) begin
      n.t = combine(p.pp);
    end else if (s == STG_FP) begin
      for (int k = 0; k < 3; k++) begin
        n.fl[k] = 64'(p.t[31:0]) * 64'(p.mag[k]);
        n.fh[k] = 64'(p.t[63:32]) * 64'(p.mag[k]);
      end
    end else if (s == STG_FN) begin
      for (int k = 0; k < 3; k++) begin
        nn        = 96'(p.fl[k]) + (96'(p.fh[k]) << 32);
        n.fsat[k] = (nn[95:31] >= {1'b0, p.d2});
        n.frem[k] = nn[94:31];
        n.flo[k]  = nn[30:0];
        n.f[k]    = '0;
      end
    end else if (s >= STG_FDIV0 && s < STG_OUT) begin
      for (int k = 0; k < 3; k++) begin
        r65      = {p.frem[k], p.flo[k][30]};
        n.flo[k] = {p.flo[k][29:0], 1'b0};
        if (r65 >= {1'b0, p.d2}) begin
          n.frem[k] = 64'(r65 - {1'b0, p.d2});
          n.f[k]    = {p.f[k][29:0], 1'b1};
        end else begin
          n.frem[k] = r65[63:0];
          n.f[k]    = {p.f[k][29:0], 1'b0};
        end
      end
    end else if (s == STG_OUT) begin
      for (int k = 0; k < 3; k++) begin
        fm = (p.fsat[k] || {1'b0, p.f[k]} > FORCE_LIMIT) ? FORCE_LIMIT : {1'b0, p.f[k]};
        if (p.status != PS_OK) begin
          n.fo[k] = '0;
        end else begin
          n.fo[k] = (p.gneg ^ p.neg[k]) ? 32'(-fm) : fm;
        end
      end
    end
    return n;
  endfunction

  logic [31:0]       cutoff_r;
  logic [63:0]       cutoff_sq_r;
  logic [NSTAGE-1:0] vld_r;
  work_t             pipe_r   [NSTAGE];
  work_t             pipe_nxt [NSTAGE];
  logic              adv;

  assign adv       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[NSTAGE-1];

  always_comb begin
    out_data.force_x     = pipe_r[NSTAGE-1].fo[0];
    out_data.force_y     = pipe_r[NSTAGE-1].fo[1];
    out_data.force_z     = pipe_r[NSTAGE-1].fo[2];
    out_data.pair_status = pipe_r[NSTAGE-1].status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_valid) begin
      cutoff_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cutoff_sq_r <= 64'(cutoff_r) * 64'(cutoff_r);
  end

  always_comb pipe_nxt[0] = capture(in_data);

  for (genvar g = 1; g < NSTAGE; g++) begin : g_stage
    always_comb pipe_nxt[g] = step(g, pipe_r[g-1], cutoff_sq_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTAGE; i++) begin
        pipe_r[i] <= pipe_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pair_status != PS_OK |->
      out_data.force_x == 32'sd0 && out_data.force_y == 32'sd0 && out_data.force_z == 32'sd0)
    else $error("nonzero force on a rejected pair");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.force_x <= $signed(FORCE_LIMIT) && out_data.force_x >= -$signed(FORCE_LIMIT) &&
      out_data.force_y <= $signed(FORCE_LIMIT) && out_data.force_y >= -$signed(FORCE_LIMIT) &&
      out_data.force_z <= $signed(FORCE_LIMIT) && out_data.force_z >= -$signed(FORCE_LIMIT))
    else $error("force outside clamp range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");
`endif

endmodule

/* tb/lennard_jones_pair_force_tb.sv */
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_tb
// Drives pair requests through the force pipeline. A built-in predictor
// computes each expected force and status, and a monitor compares every
// response against the oldest expected one. The cutoff is rewritten between
// idle phases, and the output side is stalled at random and at length.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_tb
  import ljpf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 111;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  ljpf_req_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ljpf_resp_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [31:0] cfg_data = '0;

  logic [31:0] cutoff_shadow = CUTOFF_RESET;
  ljpf_req_t   pending_reqs[$];
  ljpf_resp_t  expected_forces[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  always #5 clk = ~clk;

  lennard_jones_pair_force u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic logic [63:0] div_floor_sat(logic [127:0] num, logic [63:0] den);
    logic [127:0] quo;
    if (den == 0) return SAT64;
    quo = num / den;
    if (quo[127:64] != 0) return SAT64;
    return quo[63:0];
  endfunction

  function automatic logic [63:0] qmul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    if (p[127:96] != 0) return SAT64;
    return p[95:32];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bitv;
    r = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic ljpf_resp_t predict_force(ljpf_req_t rq, logic [31:0] cutoff);
    ljpf_resp_t rs;
    logic signed [32:0] d[3];
    logic [63:0] m[3];
    logic [65:0] d2;
    logic [63:0] eps, sig, s2, q, q3, q6, q6d, g, t, f;
    logic gneg;
    rs = '0;
    d[0] = 33'(rq.first_pos_x) - 33'(rq.second_pos_x);
    d[1] = 33'(rq.first_pos_y) - 33'(rq.second_pos_y);
    d[2] = 33'(rq.first_pos_z) - 33'(rq.second_pos_z);
    d2 = '0;
    for (int k = 0; k < 3; k++) begin
      m[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
      d2 += 66'(m[k] * m[k]);
    end
    if (d2 > 66'(64'(cutoff) * 64'(cutoff))) begin
      rs.pair_status = PS_BEYOND;
      return rs;
    end
    if (d2 == 0) begin
      rs.pair_status = PS_COINCIDENT;
      return rs;
    end
    eps = root_floor(64'(rq.first_epsilon) * 64'(rq.second_epsilon));
    sig = (64'(rq.first_sigma) + 64'(rq.second_sigma)) >> 1;
    s2 = sig * sig;
    q = div_floor_sat({32'd0, s2, 32'd0}, d2[63:0]);
    q3 = qmul_sat(qmul_sat(q, q), q);
    q6 = qmul_sat(q3, q3);
    q6d = q6[63] ? SAT64 : (q6 << 1);
    gneg = q6d < q3;
    g = gneg ? q3 - q6d : q6d - q3;
    t = qmul_sat(g, (eps * 24) << 16);
    for (int k = 0; k < 3; k++) begin
      f = div_floor_sat(t * m[k], d2[63:0]);
      if (f > 64'(FORCE_LIMIT)) f = 64'(FORCE_LIMIT);
      if (gneg != (d[k] < 0)) f = -f;
      case (k)
        0: rs.force_x = f[31:0];
        1: rs.force_y = f[31:0];
        default: rs.force_z = f[31:0];
      endcase
    end
    rs.pair_status = PS_OK;
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3) == 0 ? $urandom_range(3) : 0;
  endfunction

  int gap_in = 0;
  int gap_out = 0;
  bit tx_pause = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_forces.push_back(predict_force(in_data, cutoff_shadow));
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_in > 0 || tx_pause || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_in > 0) gap_in <= gap_in - 1;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
          gap_in <= gap_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          $display("response with none expected");
          error_count++;
        end else begin
          ljpf_resp_t w;
          w = expected_forces.pop_front();
          if (out_data.force_x !== w.force_x) report_mismatch("force_x", out_data.force_x, w.force_x);
          if (out_data.force_y !== w.force_y) report_mismatch("force_y", out_data.force_y, w.force_y);
          if (out_data.force_z !== w.force_z) report_mismatch("force_z", out_data.force_z, w.force_z);
          if (out_data.pair_status !== w.pair_status)
            report_mismatch("pair_status", 32'(out_data.pair_status), 32'(w.pair_status));
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        gap_out <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(3 << 16);
      1: return -$urandom_range(3 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic ljpf_req_t rand_pair();
    ljpf_req_t r;
    int mode;
    logic [31:0] base;
    mode = $urandom_range(9);
    base = $urandom;
    if (mode < 7) begin
      r.first_pos_x = base + (rand_coord(0) >> 1);
      r.first_pos_y = base + (rand_coord(1) >> 1);
      r.first_pos_z = base ^ 32'h0000_ffff & $urandom;
      r.second_pos_x = base;
      r.second_pos_y = base;
      r.second_pos_z = base;
      if ($urandom_range(3) == 0) r.second_pos_x = base - $urandom_range(1 << 16);
    end else begin
      r.first_pos_x = $urandom; r.first_pos_y = $urandom; r.first_pos_z = $urandom;
      r.second_pos_x = $urandom; r.second_pos_y = $urandom; r.second_pos_z = $urandom;
    end
    if ($urandom_range(4) == 0) begin
      r.first_epsilon = $urandom; r.second_epsilon = $urandom;
      r.first_sigma = $urandom; r.second_sigma = $urandom;
    end else begin
      r.first_epsilon = $urandom_range(1 << 18); r.second_epsilon = $urandom_range(1 << 18);
      r.first_sigma = $urandom_range(1 << 17); r.second_sigma = $urandom_range(1 << 17);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_forces.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cutoff_shadow = value;
  endtask

  ljpf_req_t dreq;
  logic [31:0] cutoffs[5] = '{32'hFFFF_FFFF, 32'd0, 32'd65536, 32'h0010_0000, CUTOFF_RESET};

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dreq = '0;
    pending_reqs.push_back(dreq);
    dreq.first_pos_x = 32'sd65536;
    dreq.first_epsilon = 32'd65536; dreq.second_epsilon = 32'd65536;
    dreq.first_sigma = 32'd65536; dreq.second_sigma = 32'd65536;
    pending_reqs.push_back(dreq);
    dreq.first_pos_x = 32'sd1;
    pending_reqs.push_back(dreq);
    dreq.first_pos_x = 32'h7FFF_FFFF; dreq.second_pos_x = 32'h8000_0000;
    pending_reqs.push_back(dreq);
    dreq = '1;
    pending_reqs.push_back(dreq);
    dreq.second_pos_z = 32'hFFFF_0000;
    pending_reqs.push_back(dreq);
    dreq.first_epsilon = '0;
    pending_reqs.push_back(dreq);
    dreq.first_epsilon = '1; dreq.first_sigma = '0; dreq.second_sigma = '0;
    pending_reqs.push_back(dreq);
    dreq.first_pos_y = 32'sh0001_8000; dreq.second_sigma = '1;
    pending_reqs.push_back(dreq);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_cutoff(cutoffs[ph]);
      for (int i = 0; i < 130; i++) pending_reqs.push_back(rand_pair());
      if (ph == 1) begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      if (ph == 3) begin
        wait (pending_reqs.size() < 60);
        tx_pause = 1'b1;
        while (expected_forces.size() != 0) @(posedge clk);
        tx_pause = 1'b0;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
